### rtl/ilie_pkg.sv
// shared types, codes and widths for the indexed list block
package ilie_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int ACTION_W = 3;
	localparam int POS_W = 6;
	localparam int WORD_W = 32;
	localparam int COUNT_W = 7;
	localparam int STATUS_W = 2;

	localparam logic [ACTION_W-1:0] ACT_APPEND = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_ERASE = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_READ = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_CLEAR = 3'd4;

	localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [POS_W-1:0] position;
		logic signed [WORD_W-1:0] word_in;
	} req_item_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] word_out;
		logic [COUNT_W-1:0] count;
		logic [STATUS_W-1:0] status;
	} rsp_item_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_INSERT,
		CELL_ERASE
	} cell_op_t;

	// broadcast to every cell in the row
	typedef struct packed {
		cell_op_t op;
		logic [WORD_W-1:0] word;
	} cell_ctrl_t;

endpackage

### rtl/ilie_cell.sv
// one list entry: holds, loads, or takes its left or right neighbor
module ilie_cell import ilie_pkg::*; #(
	parameter int INDEX = 0,
	parameter int CMP_W = 7
) (
	input logic clk,
	input cell_ctrl_t ctrl,
	input logic [CMP_W-1:0] tgt,
	input logic [WORD_W-1:0] left,
	input logic [WORD_W-1:0] right,
	output logic [WORD_W-1:0] q,
	output logic [WORD_W-1:0] rd
);

	localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(INDEX);

	logic [WORD_W-1:0] entry_q;
	logic [WORD_W-1:0] entry_d;
	logic hit;
	logic above;

	assign hit = (tgt == MY_IDX);
	assign above = (MY_IDX > tgt);

	always_comb begin
		entry_d = entry_q;
		case (ctrl.op)
			CELL_LOAD: begin
				if (hit) entry_d = ctrl.word;
			end
			CELL_INSERT: begin
				if (above) entry_d = left;
				else if (hit) entry_d = ctrl.word;
			end
			CELL_ERASE: begin
				if (hit || above) entry_d = right;
			end
			default: begin
				entry_d = entry_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

	assign q = entry_q;
	// masked read tap, or-ed together at the top
	assign rd = hit ? entry_q : '0;

endmodule

### rtl/indexed_list_insert_erase.sv
// top level of the indexed list with insert and erase by position
//
// channel | direction | handshake              | payload
// --------+-----------+------------------------+------------------------------
// req     | in        | req_valid / req_ready  | req_item (action, position, word_in)
// rsp     | out       | rsp_valid / rsp_ready  | rsp_item (word_out, count, status)
//
// one request per cycle while req_ready is high; its response shows up in the
// cycle after acceptance, and every action, insert and erase included, is
//   applied on acceptance: all DEPTH cells shift toward or from a neighbor in parallel
// reset clears the entry count and the response valid; entries are not cleared
// a stalled response holds; req_ready stays high while the response register
//   is empty or is being taken in the same cycle
module indexed_list_insert_erase import ilie_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input req_item_t req_item,
	output logic rsp_valid,
	input logic rsp_ready,
	output rsp_item_t rsp_item
);

	// count register width and the width used for position compares
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [CNT_W-1:0] used_q;
	logic [CNT_W-1:0] used_d;
	logic rsp_valid_q;
	rsp_item_t rsp_q;
	rsp_item_t rsp_d;

	logic accept;
	logic full;
	logic [CMP_W-1:0] pos_ext;
	logic [CMP_W-1:0] used_ext;
	logic [CMP_W-1:0] tgt;
	cell_ctrl_t ctrl;
	cell_op_t op;

	logic [WORD_W-1:0] cell_q [DEPTH];
	logic [WORD_W-1:0] cell_rd [DEPTH];
	logic [WORD_W-1:0] rd_any;
	logic [CNT_W+COUNT_W-1:0] count_wide;

	// a new request goes in whenever the response slot frees up
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept = req_valid && req_ready;

	assign full = (used_q == FULL_CNT);
	assign pos_ext = CMP_W'(req_item.position);
	assign used_ext = CMP_W'(used_q);
	// append lands at the current end, everything else at the given position
	assign tgt = (req_item.action == ACT_APPEND) ? used_ext : pos_ext;

	// decode of the action into a cell command, new count and status
	always_comb begin
		op = CELL_HOLD;
		used_d = used_q;
		rsp_d.word_out = '0;
		rsp_d.status = ST_DONE;
		case (req_item.action)
			ACT_APPEND: begin
				if (full) begin
					rsp_d.status = ST_FULL;
				end else begin
					op = CELL_LOAD;
					used_d = used_q + 1'b1;
				end
			end
			ACT_INSERT: begin
				// full check wins over the range check
				if (full) begin
					rsp_d.status = ST_FULL;
				end else if (pos_ext > used_ext) begin
					rsp_d.status = ST_RANGE;
				end else begin
					op = CELL_INSERT;
					used_d = used_q + 1'b1;
				end
			end
			ACT_ERASE: begin
				if (pos_ext >= used_ext) begin
					rsp_d.status = ST_RANGE;
				end else begin
					op = CELL_ERASE;
					used_d = used_q - 1'b1;
				end
			end
			ACT_READ: begin
				// reads at or past the end return zero
				if (pos_ext < used_ext) rsp_d.word_out = rd_any;
			end
			ACT_CLEAR: begin
				used_d = '0;
			end
			default: begin
				used_d = used_q;
			end
		endcase
		count_wide = {{COUNT_W{1'b0}}, used_d};
		rsp_d.count = count_wide[COUNT_W-1:0];
	end

	// cells only move on an accepted request
	assign ctrl.op = accept ? op : CELL_HOLD;
	assign ctrl.word = req_item.word_in;

	// row of cells, each fed by its lower and upper neighbor
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_W-1:0] left_w;
		logic [WORD_W-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = ctrl.word;
		end else begin : g_mid_l
			assign left_w = cell_q[i-1];
		end

		// the top cell has no upper neighbor; its value is past the count after an erase
		if (i == DEPTH - 1) begin : g_last
			assign right_w = cell_q[i];
		end else begin : g_mid_r
			assign right_w = cell_q[i+1];
		end

		ilie_cell #(
			.INDEX(i),
			.CMP_W(CMP_W)
		) u_cell (
			.clk(clk),
			.ctrl(ctrl),
			.tgt(tgt),
			.left(left_w),
			.right(right_w),
			.q(cell_q[i]),
			.rd(cell_rd[i])
		);
	end

	// at most one cell matches the position, so an or of the taps is the read mux
	always_comb begin
		rd_any = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_any = rd_any | cell_rd[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				used_q <= used_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// response payload, held while the consumer stalls
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item = rsp_q;

endmodule

### verif/ilie_list_checker.sv
`timescale 1ns / 100ps
// channel monitor that predicts every response of the indexed list and compares it
module ilie_list_checker import ilie_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input req_item_t req_item,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_item_t rsp_item,
	output int fail_count,
	output int pending
);

	logic signed [WORD_W-1:0] list_words [DEPTH];
	int list_len;
	int fails;
	rsp_item_t expected_rsp_q[$];

	// applies one request to the list copy and returns the response it should give
	function automatic rsp_item_t apply_request(input req_item_t r);
		rsp_item_t res;
		int len;
		int j;
		res = '0;
		res.status = ST_DONE;
		len = list_len;
		case (r.action)
			ACT_APPEND: begin
				if (len >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					list_words[len] = r.word_in;
					len++;
				end
			end
			ACT_INSERT: begin
				// full wins over a bad position
				if (len >= DEPTH) begin
					res.status = ST_FULL;
				end else if (int'(r.position) > len) begin
					res.status = ST_RANGE;
				end else begin
					for (j = len; j > int'(r.position); j--)
						list_words[j] = list_words[j-1];
					list_words[r.position] = r.word_in;
					len++;
				end
			end
			ACT_ERASE: begin
				if (int'(r.position) >= len) begin
					res.status = ST_RANGE;
				end else begin
					for (j = int'(r.position); j + 1 < len; j++)
						list_words[j] = list_words[j+1];
					len--;
				end
			end
			ACT_READ: begin
				if (int'(r.position) < len)
					res.word_out = list_words[r.position];
			end
			ACT_CLEAR: begin
				len = 0;
			end
			default: begin
			end
		endcase
		list_len = len;
		res.count = len[COUNT_W-1:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch_channels
		rsp_item_t want;
		if (!arst_n) begin
			list_len = 0;
			expected_rsp_q.delete();
		end else begin
			// the response taken now belongs to an earlier request, so pop before push
			if (rsp_valid && rsp_ready) begin
				if (expected_rsp_q.size() == 0) begin
					$error("response with nothing pending: word_out %0d count %0d status %0d",
						rsp_item.word_out, rsp_item.count, rsp_item.status);
					fails++;
				end else begin
					want = expected_rsp_q.pop_front();
					if (rsp_item.word_out !== want.word_out) begin
						$error("word_out: expected %0d, got %0d", want.word_out,
							rsp_item.word_out);
						fails++;
					end
					if (rsp_item.count !== want.count) begin
						$error("count: expected %0d, got %0d", want.count, rsp_item.count);
						fails++;
					end
					if (rsp_item.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp_item.status);
						fails++;
					end
				end
			end
			if (req_valid && req_ready)
				expected_rsp_q = {expected_rsp_q, apply_request(req_item)};
		end
		pending <= expected_rsp_q.size();
		fail_count <= fails;
	end

endmodule

### verif/indexed_list_insert_erase_tb.sv
`timescale 1ns / 100ps
// testbench top: clock, reset, request stimulus, response pacing and the verdict
module indexed_list_insert_erase_tb import ilie_pkg::*;;

	localparam int N_ITEMS = 1670;	// directed part plus about 1650 random requests
	localparam int LIST_MAX = DEPTH_DEF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid;
	logic req_ready;
	req_item_t req_item;
	logic rsp_valid;
	logic rsp_ready;
	rsp_item_t rsp_item;

	int fail_count;
	int pending;

	// entry count as the stimulus sees it, only used to aim positions
	int shadow_len = 0;
	int n_sent = 0;
	// calm stretches: no random idling on that side
	bit send_calm = 1'b0;
	bit recv_calm = 1'b0;

	indexed_list_insert_erase u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_item(req_item),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_item(rsp_item)
	);

	ilie_list_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_item(req_item),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_item(rsp_item),
		.fail_count(fail_count),
		.pending(pending)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hard stop in case the block hangs
	initial begin
		#5ms;
		$display("indexed_list_insert_erase regression: fail");
		$finish;
	end

	// idle cycles before the next request or response; often none
	function automatic int draw_gap(input bit calm);
		if (calm || $urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(0, 16);
	endfunction

	// data words lean on the signed extremes now and then
	function automatic logic [WORD_W-1:0] draw_word();
		case ($urandom_range(0, 11))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return 32'h0000_0000;
			default: return $urandom();
		endcase
	endfunction

	// offer one request, hold it until accepted, then track the count
	task automatic send_req(input logic [ACTION_W-1:0] act, input int pos,
		input logic [WORD_W-1:0] word);
		int gap;
		gap = draw_gap(send_calm);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_item <= '{action: act, position: pos[POS_W-1:0], word_in: word};
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		case (act)
			ACT_APPEND: begin
				if (shadow_len < LIST_MAX)
					shadow_len++;
			end
			ACT_INSERT: begin
				if (shadow_len < LIST_MAX && pos <= shadow_len)
					shadow_len++;
			end
			ACT_ERASE: begin
				if (pos < shadow_len)
					shadow_len--;
			end
			ACT_CLEAR: begin
				shadow_len = 0;
			end
			default: begin
			end
		endcase
		n_sent++;
		if (n_sent % 48 == 0)
			send_calm = ($urandom_range(0, 3) == 0);
	endtask

	// response side: random stalls, plus two long hold-offs that back up the block
	initial begin
		int gap;
		int n_taken;
		n_taken = 0;
		rsp_ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (n_taken == 300 || n_taken == 1000)
				gap = 400;
			else
				gap = draw_gap(recv_calm);
			if (gap > 0) begin
				rsp_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
			n_taken++;
			if (n_taken % 40 == 0)
				recv_calm = ($urandom_range(0, 3) == 0);
		end
	end

	// request side and verdict
	initial begin
		int pick;
		int w;
		int lo;
		bit first_round;
		req_valid <= 1'b0;
		req_item <= '0;
		first_round = 1'b1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty list corner cases
		send_req(ACT_READ, 0, 32'h1234_5678);
		send_req(ACT_ERASE, 0, '0);
		send_req(ACT_INSERT, 1, 32'h1111_1111);
		// signed extremes, insert at the front, at the end and in the middle
		send_req(ACT_INSERT, 0, 32'h8000_0000);
		send_req(ACT_APPEND, 63, 32'h7fff_ffff);
		send_req(ACT_APPEND, 0, 32'hffff_ffff);
		send_req(ACT_INSERT, 3, 32'h0000_0000);
		send_req(ACT_INSERT, 1, 32'h5555_5555);
		send_req(ACT_INSERT, 9, 32'haaaa_aaaa);
		send_req(ACT_READ, 0, '0);
		send_req(ACT_READ, 1, '0);
		send_req(ACT_READ, 4, '0);
		send_req(ACT_READ, 5, '0);
		send_req(ACT_READ, 63, 32'hffff_ffff);
		// erase at the front, at the last entry and past the end
		send_req(ACT_ERASE, 0, 32'hffff_ffff);
		send_req(ACT_ERASE, 3, '0);
		send_req(ACT_ERASE, 63, '0);
		send_req(ACT_READ, 2, '0);
		// unused action codes leave the list alone
		send_req(3'd5, 63, 32'hffff_ffff);
		send_req(3'd6, 0, 32'h8000_0000);
		send_req(3'd7, 42, 32'h7fff_ffff);
		send_req(ACT_CLEAR, 21, 32'hffff_ffff);
		send_req(ACT_READ, 0, '0);
		send_req(ACT_APPEND, 0, 32'haaaa_aaaa);

		// random rounds; the first one always fills the list to the top
		while (n_sent < N_ITEMS) begin
			pick = first_round ? 0 : $urandom_range(0, 19);
			first_round = 1'b0;
			if (pick < 4) begin
				// grow to full, then poke the full list
				while (shadow_len < LIST_MAX) begin
					if ($urandom_range(0, 1))
						send_req(ACT_APPEND, $urandom_range(0, 63), draw_word());
					else
						send_req(ACT_INSERT, $urandom_range(0, shadow_len), draw_word());
				end
				repeat (4)
					send_req($urandom_range(0, 1) ? ACT_INSERT : ACT_APPEND,
						$urandom_range(0, 63), draw_word());
				send_req(ACT_READ, 63, draw_word());
				send_req(ACT_READ, $urandom_range(0, 63), draw_word());
			end else if (pick < 7) begin
				// erase down to empty with reads along the way
				while (shadow_len > 0) begin
					if ($urandom_range(0, 2) == 0)
						send_req(ACT_READ, $urandom_range(0, shadow_len - 1), draw_word());
					else
						send_req(ACT_ERASE, $urandom_range(0, shadow_len - 1), draw_word());
				end
				send_req(ACT_ERASE, $urandom_range(0, 63), draw_word());
				send_req(ACT_READ, $urandom_range(0, 63), draw_word());
			end else if (pick < 17) begin
				// well-formed churn with a share of bad positions
				repeat (40) begin
					w = $urandom_range(0, 99);
					if (w < 20) begin
						if (shadow_len < LIST_MAX)
							send_req(ACT_INSERT, $urandom_range(0, shadow_len), draw_word());
						else
							send_req(ACT_INSERT, $urandom_range(0, 63), draw_word());
					end else if (w < 40) begin
						if (shadow_len > 0)
							send_req(ACT_ERASE, $urandom_range(0, shadow_len - 1), draw_word());
						else
							send_req(ACT_ERASE, $urandom_range(0, 63), draw_word());
					end else if (w < 65) begin
						if (shadow_len > 0 && $urandom_range(0, 4) != 0)
							send_req(ACT_READ, $urandom_range(0, shadow_len - 1), draw_word());
						else
							send_req(ACT_READ, $urandom_range(0, 63), draw_word());
					end else if (w < 78) begin
						send_req(ACT_APPEND, $urandom_range(0, 63), draw_word());
					end else if (w < 92) begin
						// position at or past the count
						lo = (shadow_len < 63) ? shadow_len : 63;
						case ($urandom_range(0, 2))
							0: send_req(ACT_INSERT, (lo < 63) ? $urandom_range(lo + 1, 63) : 63,
								draw_word());
							1: send_req(ACT_ERASE, $urandom_range(lo, 63), draw_word());
							default: send_req(ACT_READ, $urandom_range(lo, 63), draw_word());
						endcase
					end else if (w < 94) begin
						send_req(ACT_CLEAR, $urandom_range(0, 63), draw_word());
					end else begin
						send_req(ACTION_W'($urandom_range(5, 7)), $urandom_range(0, 63),
							draw_word());
					end
				end
			end else begin
				// raw noise over every field
				repeat (20)
					send_req(ACTION_W'($urandom_range(0, 7)), $urandom_range(0, 63),
						$urandom());
			end
		end
		req_valid <= 1'b0;
		// let the checker count the last request before looking at pending
		@(posedge clk);

		// drain outstanding responses, then keep watching for strays before the verdict
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("indexed_list_insert_erase regression: pass");
		else
			$display("indexed_list_insert_erase regression: fail");
		$finish;
	end

endmodule

### filelist.f
rtl/ilie_pkg.sv
rtl/ilie_cell.sv
rtl/indexed_list_insert_erase.sv
verif/ilie_list_checker.sv
verif/indexed_list_insert_erase_tb.sv
